// File: src/ows_pkg.sv
package ows_pkg;

    localparam int ROM_BYTES = 8;
    localparam int ROM_BITS = ROM_BYTES * 8;
    localparam int FIFO_DEPTH = 4;

    localparam logic [6:0] LAST_BPOS = 7'(ROM_BITS + 1);
    localparam logic [6:0] FAMILY_LIMIT = 7'd9;
    localparam logic [7:0] SEARCH_CMD = 8'hF0;
    localparam logic [7:0] CRC_POLY = 8'h8C;

    localparam logic [1:0] ACT_FIRST = 2'd0;
    localparam logic [1:0] ACT_NEXT = 2'd1;
    localparam logic [1:0] ACT_PRESENCE = 2'd2;
    localparam logic [1:0] ACT_BIT_PAIR = 2'd3;

    localparam logic [1:0] KIND_BUS_RESET = 2'd0;
    localparam logic [1:0] KIND_COMMAND = 2'd1;
    localparam logic [1:0] KIND_WRITE_BIT = 2'd2;
    localparam logic [1:0] KIND_FINISHED = 2'd3;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_PRESENCE = 2'd1;
    localparam logic [1:0] PH_BITS = 2'd2;

    typedef struct packed {
        logic [1:0] action;
        logic       present;
        logic       id_bit;
        logic       comp_bit;
    } t_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  command_byte;
        logic        direction_bit;
        logic        found;
        logic [63:0] rom_code;
        logic [3:0]  family_discrepancy;
        logic        last_of_run;
    } t_result;

    typedef struct packed {
        logic [1:0]  phase;
        logic [63:0] rom_bits;
        logic [6:0]  last_discrepancy;
        logic [3:0]  last_family_pos;
        logic        last_device;
        logic [6:0]  bit_position;
        logic [6:0]  last_zero_pos;
        logic [7:0]  crc_value;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase: PH_IDLE,
        rom_bits: 64'd0,
        last_discrepancy: 7'd0,
        last_family_pos: 4'd0,
        last_device: 1'b0,
        bit_position: 7'd1,
        last_zero_pos: 7'd0,
        crc_value: 8'd0
    };

    // reflected dallas crc-8 over one byte, lsb first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] c;
        logic [7:0] d;
        c = crc_in;
        d = data;
        for (int k = 0; k < 8; k++) begin
            if (c[0] ^ d[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
            d = d >> 1;
        end
        return c;
    endfunction

    function automatic t_result make_result(
        input logic [1:0]  kind,
        input logic [7:0]  cmd,
        input logic        dir,
        input logic        fnd,
        input logic [63:0] rom,
        input logic [3:0]  fam,
        input logic        last
    );
        t_result r;
        r.kind = kind;
        r.command_byte = cmd;
        r.direction_bit = dir;
        r.found = fnd;
        r.rom_code = rom;
        r.family_discrepancy = fam;
        r.last_of_run = last;
        return r;
    endfunction

endpackage

// File: src/ows_if.sv
interface ows_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic       present;
    logic       id_bit;
    logic       comp_bit;

    modport source (output valid, output action, output present, output id_bit,
                    output comp_bit, input ready);
    modport sink (input valid, input action, input present, input id_bit,
                  input comp_bit, output ready);
endinterface

interface ows_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  command_byte;
    logic        direction_bit;
    logic        found;
    logic [63:0] rom_code;
    logic [3:0]  family_discrepancy;
    logic        last_of_run;

    modport source (output valid, output kind, output command_byte, output direction_bit,
                    output found, output rom_code, output family_discrepancy,
                    output last_of_run, input ready);
    modport sink (input valid, input kind, input command_byte, input direction_bit,
                  input found, input rom_code, input family_discrepancy,
                  input last_of_run, output ready);
endinterface

// File: src/one_wire_rom_search_engine_unit.sv
// channel    dir  handshake      payload
// i_item     in   valid/ready    action, present, id_bit, comp_bit
// o_result   out  valid/ready    kind, command_byte, direction_bit, found, rom_code,
//                                family_discrepancy, last_of_run
//
// one item per cycle while the queue has room: input register, step logic, then a 4-entry
// result queue; the first result of an item is valid on o_result at the earliest once it has
// passed the input register and been written to the queue; the final bit pair yields two
// results, so output bandwidth of one result per cycle sets the rate on that item
// i_item.ready drops only while the input register holds an item and the queue has < 2 free
// i_rst_n is synchronous and active low; it clears the search state and empties the queue
module one_wire_rom_search_engine_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ows_in_if.sink    i_item,
    ows_out_if.source o_result
);
    import ows_pkg::*;

    logic       r_in_vld;
    t_item      r_in;
    t_state     r_state;
    t_state     n_state;
    logic [1:0] res_cnt;
    t_result    res0;
    t_result    res1;
    logic       room;
    logic       adv;

    assign adv = r_in_vld && room;
    assign i_item.ready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_item.ready) begin
            r_in_vld <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in.action <= i_item.action;
            r_in.present <= i_item.present;
            r_in.id_bit <= i_item.id_bit;
            r_in.comp_bit <= i_item.comp_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (adv) begin
            r_state <= n_state;
        end
    end

    ows_step u_step (
        .i_item    (r_in),
        .i_cur     (r_state),
        .o_nxt     (n_state),
        .o_res_cnt (res_cnt),
        .o_res0    (res0),
        .o_res1    (res1)
    );

    ows_result_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (adv ? res_cnt : 2'd0),
        .i_push0    (res0),
        .i_push1    (res1),
        .o_room     (room),
        .o_out      (o_result)
    );

    a_phase_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_state.phase == PH_IDLE || r_state.phase == PH_PRESENCE ||
                            r_state.phase == PH_BITS))
        else $error("unused phase code reached");

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_state.phase == PH_BITS) |->
        (r_state.bit_position >= 7'd1 && r_state.bit_position < LAST_BPOS))
        else $error("bit position out of range in bit phase");

    a_last_device: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_state.last_device) |-> (r_state.last_discrepancy == 7'd0))
        else $error("last device flagged with open discrepancy");

    a_start_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && (r_in.action == ACT_FIRST || r_in.action == ACT_NEXT)) |=>
        (r_state.bit_position == 7'd1 && r_state.crc_value == 8'd0))
        else $error("start did not rewind the search");

endmodule

// File: src/ows_step.sv
module ows_step (
    input  ows_pkg::t_item   i_item,
    input  ows_pkg::t_state  i_cur,
    output ows_pkg::t_state  o_nxt,
    output logic [1:0]       o_res_cnt,
    output ows_pkg::t_result o_res0,
    output ows_pkg::t_result o_res1
);
    import ows_pkg::*;

    always_comb begin
        logic [5:0]  idx;
        logic        dir;
        logic        ok;
        logic [63:0] rom_n;
        logic [6:0]  bp_n;

        o_nxt = i_cur;
        o_res_cnt = 2'd0;
        o_res0 = '0;
        o_res1 = '0;
        idx = i_cur.bit_position[5:0] - 6'd1;
        dir = 1'b0;
        ok = 1'b0;
        rom_n = i_cur.rom_bits;
        bp_n = i_cur.bit_position + 7'd1;

        case (i_item.action)
            ACT_FIRST, ACT_NEXT: begin
                if (i_item.action == ACT_FIRST) begin
                    o_nxt.last_discrepancy = 7'd0;
                    o_nxt.last_device = 1'b0;
                    o_nxt.last_family_pos = 4'd0;
                end
                o_nxt.bit_position = 7'd1;
                o_nxt.last_zero_pos = 7'd0;
                o_nxt.crc_value = 8'd0;
                o_res_cnt = 2'd1;
                if (o_nxt.last_device) begin
                    // last device already found, next search starts over
                    o_nxt.last_discrepancy = 7'd0;
                    o_nxt.last_device = 1'b0;
                    o_nxt.last_family_pos = 4'd0;
                    o_nxt.phase = PH_IDLE;
                    o_res0 = make_result(KIND_FINISHED, 8'd0, 1'b0, 1'b0,
                                         o_nxt.rom_bits, o_nxt.last_family_pos, 1'b1);
                end else begin
                    o_nxt.phase = PH_PRESENCE;
                    o_res0 = make_result(KIND_BUS_RESET, 8'd0, 1'b0, 1'b0,
                                         o_nxt.rom_bits, o_nxt.last_family_pos, 1'b1);
                end
            end
            ACT_PRESENCE: begin
                if (i_cur.phase == PH_PRESENCE) begin
                    o_res_cnt = 2'd1;
                    if (!i_item.present) begin
                        o_nxt.last_discrepancy = 7'd0;
                        o_nxt.last_device = 1'b0;
                        o_nxt.last_family_pos = 4'd0;
                        o_nxt.phase = PH_IDLE;
                        o_res0 = make_result(KIND_FINISHED, 8'd0, 1'b0, 1'b0,
                                             o_nxt.rom_bits, o_nxt.last_family_pos, 1'b1);
                    end else begin
                        o_nxt.phase = PH_BITS;
                        o_res0 = make_result(KIND_COMMAND, SEARCH_CMD, 1'b0, 1'b0,
                                             o_nxt.rom_bits, o_nxt.last_family_pos, 1'b1);
                    end
                end
            end
            ACT_BIT_PAIR: begin
                if (i_cur.phase == PH_BITS) begin
                    if (i_item.id_bit && i_item.comp_bit) begin
                        // no device answered
                        o_nxt.last_discrepancy = 7'd0;
                        o_nxt.last_device = 1'b0;
                        o_nxt.last_family_pos = 4'd0;
                        o_nxt.phase = PH_IDLE;
                        o_res_cnt = 2'd1;
                        o_res0 = make_result(KIND_FINISHED, 8'd0, 1'b0, 1'b0,
                                             o_nxt.rom_bits, o_nxt.last_family_pos, 1'b1);
                    end else begin
                        if (i_item.id_bit != i_item.comp_bit) begin
                            dir = i_item.id_bit;
                        end else begin
                            if (i_cur.bit_position < i_cur.last_discrepancy) begin
                                dir = i_cur.rom_bits[idx];
                            end else begin
                                dir = (i_cur.bit_position == i_cur.last_discrepancy);
                            end
                            if (!dir) begin
                                o_nxt.last_zero_pos = i_cur.bit_position;
                                if (i_cur.bit_position < FAMILY_LIMIT) begin
                                    o_nxt.last_family_pos = i_cur.bit_position[3:0];
                                end
                            end
                        end
                        rom_n[idx] = dir;
                        o_nxt.rom_bits = rom_n;
                        if (idx[2:0] == 3'b111) begin
                            o_nxt.crc_value = crc8_byte(i_cur.crc_value,
                                                        rom_n[{idx[5:3], 3'b000} +: 8]);
                        end
                        o_nxt.bit_position = bp_n;
                        if (bp_n < LAST_BPOS) begin
                            o_res_cnt = 2'd1;
                            o_res0 = make_result(KIND_WRITE_BIT, 8'd0, dir, 1'b0,
                                                 rom_n, o_nxt.last_family_pos, 1'b1);
                        end else begin
                            o_res_cnt = 2'd2;
                            o_res0 = make_result(KIND_WRITE_BIT, 8'd0, dir, 1'b0,
                                                 rom_n, o_nxt.last_family_pos, 1'b0);
                            o_nxt.phase = PH_IDLE;
                            ok = (o_nxt.crc_value == 8'd0);
                            if (ok) begin
                                o_nxt.last_discrepancy = o_nxt.last_zero_pos;
                                if (o_nxt.last_zero_pos == 7'd0) begin
                                    o_nxt.last_device = 1'b1;
                                end
                            end
                            if (!ok || rom_n[7:0] == 8'd0) begin
                                o_nxt.last_discrepancy = 7'd0;
                                o_nxt.last_device = 1'b0;
                                o_nxt.last_family_pos = 4'd0;
                                ok = 1'b0;
                            end
                            o_res1 = make_result(KIND_FINISHED, 8'd0, 1'b0, ok,
                                                 rom_n, o_nxt.last_family_pos, 1'b1);
                        end
                    end
                end
            end
            default: begin
                o_res_cnt = 2'd0;
            end
        endcase
    end

endmodule

// File: src/ows_result_fifo.sv
module ows_result_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_push_cnt,
    input  ows_pkg::t_result i_push0,
    input  ows_pkg::t_result i_push1,
    output logic             o_room,
    ows_out_if.source        o_out
);
    import ows_pkg::*;

    t_result    r_mem [FIFO_DEPTH];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_count;
    logic [2:0] n_count;
    logic       pop;
    t_result    head;

    assign pop = o_out.valid && o_out.ready;
    assign n_count = r_count + {1'b0, i_push_cnt} - {2'b0, pop};
    // room for a full run of two results
    assign o_room = (r_count <= 3'(FIFO_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count <= 3'd0;
        end else begin
            r_wr_ptr <= r_wr_ptr + i_push_cnt;
            r_rd_ptr <= r_rd_ptr + {1'b0, pop};
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[r_wr_ptr + 2'd1] <= i_push1;
        end
    end

    assign head = r_mem[r_rd_ptr];
    assign o_out.valid = (r_count != 3'd0);
    assign o_out.kind = head.kind;
    assign o_out.command_byte = head.command_byte;
    assign o_out.direction_bit = head.direction_bit;
    assign o_out.found = head.found;
    assign o_out.rom_code = head.rom_code;
    assign o_out.family_discrepancy = head.family_discrepancy;
    assign o_out.last_of_run = head.last_of_run;

endmodule
